// ----- rtl/core/euca_pkg.sv -----
// ----------------------------------------------------------------------------
// euca_pkg
// Shared types and constants for the epidemic cell automaton update core.
// ----------------------------------------------------------------------------
package euca_pkg;

  localparam int STATE_W = 2;
  localparam int AGE_W   = 11;
  localparam int RND_W   = 7;
  localparam int LIMIT_W = 10;
  localparam int NBR_N   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int VOTE_W  = 5;   // nine cells, two votes at most each

  localparam logic signed [AGE_W-1:0] AGE_MAX = 11'sd1023;

  typedef enum logic [STATE_W-1:0] {
    ST_HEALTHY = 2'd0,
    ST_ILL     = 2'd1,
    ST_DEAD    = 2'd2,
    ST_EMPTY   = 2'd3
  } cell_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEALTHY_LIFE = 3'd0,
    CFG_ILLNESS      = 3'd1,
    CFG_DECAY        = 3'd2,
    CFG_EMPTY        = 3'd3,
    CFG_REGROW       = 3'd4
  } cfg_index_t;

  localparam logic [LIMIT_W-1:0] RST_HEALTHY_LIFE = 10'd50;
  localparam logic [LIMIT_W-1:0] RST_ILLNESS      = 10'd20;
  localparam logic [LIMIT_W-1:0] RST_DECAY        = 10'd80;
  localparam logic [LIMIT_W-1:0] RST_EMPTY        = 10'd200;
  localparam logic [LIMIT_W-1:0] RST_REGROW       = 10'd120;

  typedef struct packed {
    logic [LIMIT_W-1:0] healthy_life;
    logic [LIMIT_W-1:0] illness;
    logic [LIMIT_W-1:0] decay;
    logic [LIMIT_W-1:0] empty;
    logic [LIMIT_W-1:0] regrow;
  } limits_t;

  // Neighbour order follows the presence bits: NW, N, NE, W, E, SW, S, SE
  typedef struct packed {
    cell_state_t              centre;
    cell_state_t [NBR_N-1:0]  nbr;
    logic [NBR_N-1:0]         present;
  } window_t;

endpackage

// ----- rtl/core/euca_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// euca_cfg_regs
// Age limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module euca_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [euca_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [euca_pkg::LIMIT_W-1:0]        wr_data,
  output euca_pkg::limits_t                   limits
);
  import euca_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.healthy_life <= RST_HEALTHY_LIFE;
      limits.illness      <= RST_ILLNESS;
      limits.decay        <= RST_DECAY;
      limits.empty        <= RST_EMPTY;
      limits.regrow       <= RST_REGROW;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_HEALTHY_LIFE: limits.healthy_life <= wr_data;
        CFG_ILLNESS:      limits.illness      <= wr_data;
        CFG_DECAY:        limits.decay        <= wr_data;
        CFG_EMPTY:        limits.empty        <= wr_data;
        CFG_REGROW:       limits.regrow       <= wr_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

endmodule

// ----- rtl/core/euca_vote.sv -----
// ----------------------------------------------------------------------------
// euca_vote
// Weighted vote over the 3x3 window; returns the dominant state.
// ----------------------------------------------------------------------------
module euca_vote (
  input  euca_pkg::window_t      win,
  output euca_pkg::cell_state_t  dominant
);
  import euca_pkg::*;

  logic [VOTE_W-1:0] votes [4];

  function automatic logic [VOTE_W-1:0] weight(input cell_state_t s);
    weight = (s == ST_ILL) ? VOTE_W'(2) : VOTE_W'(1);
  endfunction

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      votes[s] = '0;
    end
    votes[win.centre] = votes[win.centre] + weight(win.centre);
    for (int k = 0; k < NBR_N; k++) begin
      if (win.present[k]) begin
        votes[win.nbr[k]] = votes[win.nbr[k]] + weight(win.nbr[k]);
      end
    end
  end

  // strict compares so a tie stays with the lower code
  always_comb begin
    dominant = ST_HEALTHY;
    if (votes[1] > votes[dominant]) dominant = ST_ILL;
    if (votes[2] > votes[dominant]) dominant = ST_DEAD;
    if (votes[3] > votes[dominant]) dominant = ST_EMPTY;
  end

endmodule

// ----- rtl/core/euca_rule.sv -----
// ----------------------------------------------------------------------------
// euca_rule
// Infection, ageing and age-limit transitions for one cell.
// ----------------------------------------------------------------------------
module euca_rule (
  input  euca_pkg::cell_state_t                 state_in,
  input  logic signed [euca_pkg::AGE_W-1:0]     age_in,
  input  logic signed [euca_pkg::RND_W-1:0]     rnd,
  input  euca_pkg::cell_state_t                 dominant,
  input  euca_pkg::limits_t                     limits,
  output euca_pkg::cell_state_t                 state_out,
  output logic signed [euca_pkg::AGE_W-1:0]     age_out
);
  import euca_pkg::*;

  cell_state_t              st;
  logic signed [AGE_W-1:0]  age;
  logic signed [AGE_W-1:0]  age_inc;
  logic signed [AGE_W-1:0]  rnd_ext;

  function automatic logic over(input logic signed [AGE_W-1:0] a,
                                input logic [LIMIT_W-1:0] lim);
    over = a > $signed({1'b0, lim});
  endfunction

  assign rnd_ext = AGE_W'(rnd);

  always_comb begin
    st  = state_in;
    age = age_in;
    if (state_in == ST_HEALTHY && dominant == ST_ILL) begin
      st  = ST_ILL;
      age = '0;
    end
    age_inc = (age != AGE_MAX) ? age + AGE_W'(1) : age;

    state_out = st;
    age_out   = age_inc;
    case (st)
      ST_HEALTHY: if (over(age_inc, limits.healthy_life)) begin
        state_out = ST_ILL;
        age_out   = rnd_ext;
      end
      ST_ILL: if (over(age_inc, limits.illness)) begin
        state_out = ST_DEAD;
        age_out   = rnd_ext;
      end
      ST_DEAD: if (over(age_inc, limits.decay)) begin
        state_out = ST_EMPTY;
        age_out   = rnd_ext;
      end
      default: if (over(age_inc, limits.empty) ||
                   (over(age_inc, limits.regrow) && dominant == ST_HEALTHY)) begin
        state_out = ST_HEALTHY;
        age_out   = rnd_ext;
      end
    endcase
  end

endmodule

// ----- rtl/core/epidemic_cell_automaton_update_core.sv -----
// ----------------------------------------------------------------------------
// epidemic_cell_automaton_update_core
// Next-generation update of one cell from its 3x3 window.
// Each input transaction passes through the input reg, then the result reg.
// Throughput: one window per cycle; ready drops only when both stages are
// full and the result is not taken.
// Reset clears both valid stages and loads the default age limits.
// ----------------------------------------------------------------------------
module epidemic_cell_automaton_update_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [euca_pkg::STATE_W-1:0]          centre_state,
  input  logic signed [euca_pkg::AGE_W-1:0]     centre_age,
  input  logic signed [euca_pkg::RND_W-1:0]     random_age,
  input  logic [euca_pkg::STATE_W-1:0]          north_west_state,
  input  logic [euca_pkg::STATE_W-1:0]          north_state,
  input  logic [euca_pkg::STATE_W-1:0]          north_east_state,
  input  logic [euca_pkg::STATE_W-1:0]          west_state,
  input  logic [euca_pkg::STATE_W-1:0]          east_state,
  input  logic [euca_pkg::STATE_W-1:0]          south_west_state,
  input  logic [euca_pkg::STATE_W-1:0]          south_state,
  input  logic [euca_pkg::STATE_W-1:0]          south_east_state,
  input  logic [euca_pkg::NBR_N-1:0]            neighbour_present,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [euca_pkg::STATE_W-1:0]          next_state,
  output logic signed [euca_pkg::AGE_W-1:0]     next_age,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [euca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [euca_pkg::LIMIT_W-1:0]          cfg_data
);
  import euca_pkg::*;

  limits_t                  limits;

  // input register stage
  logic                     s1_valid;
  window_t                  s1_win;
  logic signed [AGE_W-1:0]  s1_age;
  logic signed [RND_W-1:0]  s1_rnd;

  logic                     s1_ready;
  logic                     s2_ready;
  window_t                  win_in;
  cell_state_t              dominant;
  cell_state_t              state_calc;
  logic signed [AGE_W-1:0]  age_calc;

  assign cfg_ready = 1'b1;

  euca_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    win_in.centre  = cell_state_t'(centre_state);
    win_in.nbr[0]  = cell_state_t'(north_west_state);
    win_in.nbr[1]  = cell_state_t'(north_state);
    win_in.nbr[2]  = cell_state_t'(north_east_state);
    win_in.nbr[3]  = cell_state_t'(west_state);
    win_in.nbr[4]  = cell_state_t'(east_state);
    win_in.nbr[5]  = cell_state_t'(south_west_state);
    win_in.nbr[6]  = cell_state_t'(south_state);
    win_in.nbr[7]  = cell_state_t'(south_east_state);
    win_in.present = neighbour_present;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_win <= win_in;
      s1_age <= centre_age;
      s1_rnd <= random_age;
    end
  end

  euca_vote u_vote (
    .win      (s1_win),
    .dominant (dominant)
  );

  euca_rule u_rule (
    .state_in  (s1_win.centre),
    .age_in    (s1_age),
    .rnd       (s1_rnd),
    .dominant  (dominant),
    .limits    (limits),
    .state_out (state_calc),
    .age_out   (age_calc)
  );

  // result register: holds while the downstream side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      next_state <= state_calc;
      next_age   <= age_calc;
    end
  end

endmodule

// ----- sim/epidemic_cell_automaton_update_core_test.sv -----
// ----------------------------------------------------------------------------
// epidemic_cell_automaton_update_core_test
// Self-checking bench for the cell update core. A short table of windows
// (ages at the extremes, limits at zero and at the top, vote ties) is
// followed by random windows with ages clustered round the active limit,
// under several limit settings and three idling mixes. Every result is
// checked against the table's expected value or a next-generation predictor in the bench.
// ----------------------------------------------------------------------------
module epidemic_cell_automaton_update_core_test;
  import euca_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int CLK_PERIOD     = 2 * CLK_HALF;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int AGE_LOW        = -64;
  localparam int AGE_HIGH       = int'(AGE_MAX);
  localparam int DIR_ROWS       = 25;

  typedef enum logic [1:0] {
    LIM_RESET,
    LIM_ZERO,
    LIM_TOP
  } lim_set_t;

  typedef struct packed {
    window_t                 win;
    logic signed [AGE_W-1:0] age;
    logic signed [RND_W-1:0] rnd;
  } cell_item_t;

  typedef struct packed {
    cell_state_t             state;
    logic signed [AGE_W-1:0] age;
  } cell_next_t;

  // nbrs holds the eight neighbour states, NW in the low two bits
  typedef struct packed {
    lim_set_t                lim;
    cell_state_t             centre;
    logic signed [AGE_W-1:0] age;
    logic signed [RND_W-1:0] rnd;
    logic [2*NBR_N-1:0]      nbrs;
    logic [NBR_N-1:0]        present;
    logic                    fixed;
    cell_state_t             exp_state;
    logic signed [AGE_W-1:0] exp_age;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid;
  logic                  in_ready;
  logic [STATE_W-1:0]    centre_state;
  logic signed [AGE_W-1:0] centre_age;
  logic signed [RND_W-1:0] random_age;
  logic [STATE_W-1:0]    north_west_state;
  logic [STATE_W-1:0]    north_state;
  logic [STATE_W-1:0]    north_east_state;
  logic [STATE_W-1:0]    west_state;
  logic [STATE_W-1:0]    east_state;
  logic [STATE_W-1:0]    south_west_state;
  logic [STATE_W-1:0]    south_state;
  logic [STATE_W-1:0]    south_east_state;
  logic [NBR_N-1:0]      neighbour_present;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATE_W-1:0]    next_state;
  logic signed [AGE_W-1:0] next_age;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LIMIT_W-1:0]    cfg_data;

  cell_next_t gen_due_q[$];
  cell_next_t gen_seen;
  limits_t    lim_now = '{RST_HEALTHY_LIFE, RST_ILLNESS, RST_DECAY, RST_EMPTY, RST_REGROW};
  int         mismatch_count = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  bit         hold_pending   = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{LIM_RESET, ST_HEALTHY,    0,   0, 16'h0000, 8'h00, 1'b1, ST_HEALTHY,    1},
    '{LIM_RESET, ST_HEALTHY,   50, -64, 16'h0000, 8'h00, 1'b1, ST_ILL,      -64},
    '{LIM_RESET, ST_ILL,     1023,  63, 16'h0000, 8'h00, 1'b1, ST_DEAD,      63},
    '{LIM_RESET, ST_EMPTY,   1023,  -1, 16'h0000, 8'h00, 1'b1, ST_HEALTHY,   -1},
    '{LIM_RESET, ST_DEAD,     -64,   0, 16'h0000, 8'h00, 1'b1, ST_DEAD,     -63},
    '{LIM_RESET, ST_HEALTHY,   -1,   0, 16'h0000, 8'h00, 1'b1, ST_HEALTHY,    0},
    '{LIM_RESET, ST_ILL,       19,   0, 16'h0000, 8'h00, 1'b1, ST_ILL,       20},
    '{LIM_RESET, ST_DEAD,      80,   5, 16'h0000, 8'h00, 1'b1, ST_EMPTY,      5},
    '{LIM_RESET, ST_HEALTHY,  500,   0, 16'h5555, 8'hFF, 1'b1, ST_ILL,        1},
    '{LIM_RESET, ST_HEALTHY,   10,   0, 16'h5555, 8'h00, 1'b1, ST_HEALTHY,   11},
    // healthy/ill tie, dead/empty tie, regrow with and without a tie
    '{LIM_RESET, ST_HEALTHY,    3,   0, 16'h0004, 8'h03, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_EMPTY,    150,   9, 16'h0002, 8'h01, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_EMPTY,    120,   7, 16'h0000, 8'h03, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_EMPTY,    120,  -7, 16'hFFFC, 8'h01, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_HEALTHY,   30,   1, 16'h1111, 8'h55, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_DEAD,     200,  42, 16'hAAAA, 8'hAA, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_ILL,      700, -33, 16'h1B1B, 8'hFF, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_EMPTY,    119,   3, 16'hFFFF, 8'hFF, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_EMPTY,    200,  11, 16'hAAAA, 8'hFF, 1'b0, ST_HEALTHY,    0},
    '{LIM_RESET, ST_DEAD,      33, -20, 16'hE4E4, 8'h3C, 1'b0, ST_HEALTHY,    0},
    '{LIM_ZERO,  ST_HEALTHY,    0,  21, 16'h0000, 8'h00, 1'b1, ST_ILL,       21},
    '{LIM_ZERO,  ST_EMPTY,     -1,   0, 16'h0000, 8'h00, 1'b1, ST_EMPTY,      0},
    '{LIM_ZERO,  ST_DEAD,    1023, -64, 16'h0000, 8'h00, 1'b1, ST_EMPTY,    -64},
    '{LIM_TOP,   ST_HEALTHY, 1023,   0, 16'h0000, 8'h00, 1'b1, ST_HEALTHY, 1023},
    '{LIM_TOP,   ST_ILL,     1023,   0, 16'h5555, 8'hFF, 1'b1, ST_ILL,     1023}
  };

  epidemic_cell_automaton_update_core u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .centre_state      (centre_state),
    .centre_age        (centre_age),
    .random_age        (random_age),
    .north_west_state  (north_west_state),
    .north_state       (north_state),
    .north_east_state  (north_east_state),
    .west_state        (west_state),
    .east_state        (east_state),
    .south_west_state  (south_west_state),
    .south_state       (south_state),
    .south_east_state  (south_east_state),
    .neighbour_present (neighbour_present),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .next_state        (next_state),
    .next_age          (next_age),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic cell_next_t next_generation(input cell_item_t it, input limits_t lm);
    int          votes [4];
    int          dom;
    int          age;
    cell_state_t st;
    cell_next_t  res;
    votes = '{default: 0};
    st = it.win.centre;
    votes[st] += (st == ST_ILL) ? 2 : 1;
    for (int k = 0; k < NBR_N; k++) begin
      if (it.win.present[k]) begin
        votes[it.win.nbr[k]] += (it.win.nbr[k] == ST_ILL) ? 2 : 1;
      end
    end
    dom = 0;
    for (int k = 1; k < 4; k++) begin
      if (votes[k] > votes[dom]) dom = k;
    end
    age = int'($signed(it.age));
    if (st == ST_HEALTHY && dom == int'(ST_ILL)) begin
      st  = ST_ILL;
      age = 0;
    end
    if (age < AGE_HIGH) age++;
    // limits are unsigned registers but compared against a signed age
    case (st)
      ST_HEALTHY: if (age > int'(lm.healthy_life)) begin
        st  = ST_ILL;
        age = int'($signed(it.rnd));
      end
      ST_ILL: if (age > int'(lm.illness)) begin
        st  = ST_DEAD;
        age = int'($signed(it.rnd));
      end
      ST_DEAD: if (age > int'(lm.decay)) begin
        st  = ST_EMPTY;
        age = int'($signed(it.rnd));
      end
      default: if (age > int'(lm.empty) ||
                   (age > int'(lm.regrow) && dom == int'(ST_HEALTHY))) begin
        st  = ST_HEALTHY;
        age = int'($signed(it.rnd));
      end
    endcase
    res.state = st;
    res.age   = age[AGE_W-1:0];
    return res;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_W'(1000);
      3, 4:    return LIMIT_W'($urandom_range(40));
      default: return LIMIT_W'($urandom_range(1000));
    endcase
  endfunction

  // Ages often land close to the limit that governs the centre state
  function automatic cell_item_t random_window(input limits_t lm);
    cell_item_t  it;
    cell_state_t theme;
    int          lim_val;
    int          a;
    theme = cell_state_t'($urandom_range(3));
    it.win.centre = cell_state_t'($urandom_range(3));
    for (int k = 0; k < NBR_N; k++) begin
      if ($urandom_range(1) && $urandom_range(3) != 0) it.win.nbr[k] = theme;
      else it.win.nbr[k] = cell_state_t'($urandom_range(3));
    end
    it.win.present = $urandom_range(1) ? '1 : NBR_N'($urandom);
    case (it.win.centre)
      ST_HEALTHY: lim_val = int'(lm.healthy_life);
      ST_ILL:     lim_val = int'(lm.illness);
      ST_DEAD:    lim_val = int'(lm.decay);
      default:    lim_val = $urandom_range(1) ? int'(lm.empty) : int'(lm.regrow);
    endcase
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       a = AGE_LOW;
          1:       a = -1;
          2:       a = 0;
          3:       a = AGE_HIGH - 1;
          default: a = AGE_HIGH;
        endcase
      end
      1, 2, 3, 4: a = lim_val + int'($urandom_range(6)) - 4;
      default:    a = int'($urandom_range(AGE_HIGH - AGE_LOW)) + AGE_LOW;
    endcase
    if (a < AGE_LOW) a = AGE_LOW;
    if (a > AGE_HIGH) a = AGE_HIGH;
    it.age = a[AGE_W-1:0];
    it.rnd = RND_W'($urandom);
    return it;
  endfunction

  task automatic log_error(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic offer_window(input cell_item_t it, input bit fixed, input cell_next_t fixed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    centre_state      <= it.win.centre;
    centre_age        <= it.age;
    random_age        <= it.rnd;
    north_west_state  <= it.win.nbr[0];
    north_state       <= it.win.nbr[1];
    north_east_state  <= it.win.nbr[2];
    west_state        <= it.win.nbr[3];
    east_state        <= it.win.nbr[4];
    south_west_state  <= it.win.nbr[5];
    south_state       <= it.win.nbr[6];
    south_east_state  <= it.win.nbr[7];
    neighbour_present <= it.win.present;
    do @(posedge clk); while (!in_ready);
    gen_due_q.push_back(fixed ? fixed_res : next_generation(it, lim_now));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gen_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused indexes get random data, which the block must ignore
  task automatic write_limits(input limits_t lm, input bit with_unused);
    write_reg(CFG_HEALTHY_LIFE, lm.healthy_life);
    write_reg(CFG_ILLNESS, lm.illness);
    write_reg(CFG_DECAY, lm.decay);
    write_reg(CFG_EMPTY, lm.empty);
    write_reg(CFG_REGROW, lm.regrow);
    if (with_unused) begin
      for (int i = int'(CFG_REGROW) + 1; i < 2**CFG_IDX_W; i++) begin
        write_reg(CFG_IDX_W'(i), LIMIT_W'($urandom));
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEALTHY_LIFE: lim_now.healthy_life = cfg_data;
          CFG_ILLNESS:      lim_now.illness      = cfg_data;
          CFG_DECAY:        lim_now.decay        = cfg_data;
          CFG_EMPTY:        lim_now.empty        = cfg_data;
          CFG_REGROW:       lim_now.regrow       = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (gen_due_q.size() == 0) begin
          log_error($sformatf("unexpected transaction: state %0d age %0d",
                              next_state, next_age));
        end else begin
          gen_seen = gen_due_q.pop_front();
          if (next_state !== gen_seen.state || next_age !== gen_seen.age) begin
            log_error($sformatf("mismatch: state %0d age %0d, expected state %0d age %0d",
                                next_state, next_age, gen_seen.state,
                                $signed(gen_seen.age)));
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  initial begin
    cell_item_t it;
    cell_next_t fixed_res;
    limits_t    lm;
    lim_set_t   lim_cur;
    in_valid          = 1'b0;
    centre_state      = '0;
    centre_age        = '0;
    random_age        = '0;
    north_west_state  = '0;
    north_state       = '0;
    north_east_state  = '0;
    west_state        = '0;
    east_state        = '0;
    south_west_state  = '0;
    south_state       = '0;
    south_east_state  = '0;
    neighbour_present = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    send_idle_pct     = 30;
    recv_idle_pct     = 64;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    lim_cur = LIM_RESET;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].lim != lim_cur) begin
        wait_results_drained();
        lim_cur = dir_rows[r].lim;
        case (lim_cur)
          LIM_ZERO: lm = '{default: '0};
          LIM_TOP:  lm = '{default: '1};
          default:  lm = '{RST_HEALTHY_LIFE, RST_ILLNESS, RST_DECAY, RST_EMPTY, RST_REGROW};
        endcase
        write_limits(lm, lim_cur == LIM_ZERO);
      end
      it.win.centre  = dir_rows[r].centre;
      it.win.present = dir_rows[r].present;
      for (int k = 0; k < NBR_N; k++) begin
        it.win.nbr[k] = cell_state_t'(dir_rows[r].nbrs[2*k +: 2]);
      end
      it.age          = dir_rows[r].age;
      it.rnd          = dir_rows[r].rnd;
      fixed_res.state = dir_rows[r].exp_state;
      fixed_res.age   = dir_rows[r].exp_age;
      offer_window(it, dir_rows[r].fixed, fixed_res);
    end

    // Idling mixes: sender-light, receiver-light, then none at all
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 30 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        wait_results_drained();
        lm.healthy_life = pick_limit();
        lm.illness      = pick_limit();
        lm.decay        = pick_limit();
        lm.empty        = pick_limit();
        lm.regrow       = pick_limit();
        write_limits(lm, seg == 0);
        if (ph == 2 && seg == 3) begin
          // long output stall while windows keep coming: the core must fill
          hold_pending = 1'b1;
          repeat (12) offer_window(random_window(lim_now), 1'b0, fixed_res);
        end
        repeat (70) offer_window(random_window(lim_now), 1'b0, fixed_res);
      end
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && gen_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
